[design/i2cm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // One bus tick offered to the sequencer
  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [7:0] cmd_byte;
    logic       sda_in;
  } tick_t;

  // Bus levels and status after the tick
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] read_value;
  } result_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 24;

  localparam logic [CfgIndexWidth-1:0] REG_ADDRESS_BYTE    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_PHASE_TICKS     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ACK_TIMEOUT     = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_STOP_HOLD_TICKS = 2'd3;

  localparam logic [7:0]  ADDRESS_BYTE_RESET    = 8'd70;
  localparam logic [15:0] PHASE_TICKS_RESET     = 16'd50;
  localparam logic [15:0] ACK_TIMEOUT_RESET     = 16'd500;
  localparam logic [23:0] STOP_HOLD_TICKS_RESET = 24'd100000;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_ADDR_ACK = 2'd1;
  localparam logic [1:0] STATUS_NO_DATA_ACK = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

endpackage

`default_nettype wire

[design/i2cm_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_tick_if;
  import i2cm_pkg::*;

  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_result_if;
  import i2cm_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/i2c_sensor_command_and_read_master.sv]
// I2C master sequencer for a sensor that takes command bytes and returns
// two-byte measurements.
//
// tick:   one request per bus tick: an optional write/read request and the
//         sampled SDA level. A request is taken only while the bus is idle.
// result: one result per accepted tick: SCL/SDA levels, busy, a one-tick
//         done pulse with status, and the 16-bit read value on done of a read with status OK.
// cfg:    register writes (address byte, phase length, acknowledge timeout,
//         hold after STOP); the user makes them while no transaction runs, the block does not enforce it.
//
// The sequencer state and the output result register are both loaded at the
// clock edge that accepts a tick. With the result side ready, a tick is
// accepted every cycle.
// When the receiver stalls, the result register holds; tick.ready stays high
// as long as the held result is taken in the same cycle.
// Reset (synchronous) puts the sequencer in idle, clears the result valid flag
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module i2c_sensor_command_and_read_master (
  input  wire                                  clk,
  input  wire                                  rst,
  i2cm_tick_if.sink                            tick,
  i2cm_result_if.source                        result,
  input  wire                                  cfg_write,
  input  wire [i2cm_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire [i2cm_pkg::CfgDataWidth-1:0]     cfg_data
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_A,
    ST_START_B,
    ST_TX_LO,
    ST_TX_HI,
    ST_ACK_LO,
    ST_ACK_POLL,
    ST_RX_LO,
    ST_RX_HI,
    ST_MACK_LO,
    ST_MACK_HI,
    ST_STOP_A,
    ST_STOP_B,
    ST_STOP_C,
    ST_HOLD
  } state_t;

  // Configuration registers
  logic [7:0]  address_byte;
  logic [15:0] phase_ticks;
  logic [15:0] ack_timeout;
  logic [23:0] stop_hold_ticks;

  // Sequencer state
  state_t      state, state_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] ack_poll_count, ack_poll_count_next;
  logic [23:0] stop_hold_count, stop_hold_count_next;
  logic [15:0] read_accum, read_accum_next;
  logic        request_kind, request_kind_next;
  logic [1:0]  pending_status, pending_status_next;

  logic        tick_fire;
  logic        res_valid;
  result_t     res_data, res_next;

  logic [15:0] phase_limit;
  logic [15:0] phase_count;
  logic        phase_end;
  logic [23:0] hold_count;
  logic        finish;
  tick_t       in;

  assign in          = tick.data;
  assign tick.ready  = !res_valid || result.ready;
  assign tick_fire   = tick.valid && tick.ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  assign phase_limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign phase_count = 16'(phase_timer + 16'd1);
  assign phase_end   = phase_count >= phase_limit;
  assign hold_count  = 24'(stop_hold_count + 24'd1);

  always_comb begin
    state_next           = state;
    phase_timer_next     = phase_timer;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    ack_poll_count_next  = ack_poll_count;
    stop_hold_count_next = stop_hold_count;
    read_accum_next      = read_accum;
    request_kind_next    = request_kind;
    pending_status_next  = pending_status;
    finish               = 1'b0;

    // Timed phases: advance the phase timer, clear it when the phase ends
    if (state == ST_START_A || state == ST_START_B || state == ST_TX_LO ||
        state == ST_TX_HI || state == ST_ACK_LO || state == ST_RX_LO ||
        state == ST_RX_HI || state == ST_MACK_LO || state == ST_MACK_HI ||
        state == ST_STOP_A || state == ST_STOP_B || state == ST_STOP_C) begin
      phase_timer_next = phase_end ? 16'd0 : phase_count;
    end

    unique case (state)
      ST_IDLE: begin
        if (in.req_valid) begin
          request_kind_next    = in.req_type;
          shift_reg_next       = address_byte | {7'd0, in.req_type};
          read_accum_next      = (in.req_type == REQ_READ) ? 16'd0 : {8'd0, in.cmd_byte};
          bit_count_next       = 4'd0;
          ack_poll_count_next  = 16'd0;
          stop_hold_count_next = 24'd0;
          pending_status_next  = STATUS_OK;
          state_next           = ST_START_A;
          phase_timer_next     = 16'd0;
        end
      end
      ST_START_A: if (phase_end) state_next = ST_START_B;
      ST_START_B: if (phase_end) state_next = ST_TX_LO;
      ST_TX_LO:   if (phase_end) state_next = ST_TX_HI;
      ST_TX_HI: begin
        if (phase_end) begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = 4'(bit_count + 4'd1);
          state_next     = (bit_count_next[2:0] == 3'd0) ? ST_ACK_LO : ST_TX_LO;
        end
      end
      ST_ACK_LO: begin
        if (phase_end) begin
          ack_poll_count_next = 16'd0;
          state_next          = ST_ACK_POLL;
        end
      end
      ST_ACK_POLL: begin
        if (!in.sda_in) begin
          if (bit_count == 4'd8 && request_kind == REQ_READ) begin
            bit_count_next  = 4'd0;
            read_accum_next = 16'd0;
            state_next      = ST_RX_LO;
          end else if (bit_count == 4'd8) begin
            shift_reg_next = read_accum[7:0];
            state_next     = ST_TX_LO;
          end else begin
            state_next = ST_STOP_A;
          end
          phase_timer_next = 16'd0;
        end else if (ack_poll_count >= ack_timeout) begin
          pending_status_next = (bit_count == 4'd8) ? STATUS_NO_ADDR_ACK : STATUS_NO_DATA_ACK;
          state_next          = ST_STOP_A;
          phase_timer_next    = 16'd0;
        end else begin
          ack_poll_count_next = 16'(ack_poll_count + 16'd1);
        end
      end
      ST_RX_LO: if (phase_end) state_next = ST_RX_HI;
      ST_RX_HI: begin
        if (phase_end) begin
          read_accum_next = {read_accum[14:0], in.sda_in};
          bit_count_next  = 4'(bit_count + 4'd1);
          state_next      = (bit_count_next[2:0] == 3'd0) ? ST_MACK_LO : ST_RX_LO;
        end
      end
      ST_MACK_LO: if (phase_end) state_next = ST_MACK_HI;
      ST_MACK_HI: begin
        if (phase_end) state_next = (bit_count == 4'd8) ? ST_RX_LO : ST_STOP_A;
      end
      ST_STOP_A: if (phase_end) state_next = ST_STOP_B;
      ST_STOP_B: if (phase_end) state_next = ST_STOP_C;
      ST_STOP_C: begin
        if (phase_end) begin
          stop_hold_count_next = 24'd0;
          if (stop_hold_ticks == 24'd0) finish = 1'b1;
          else state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        stop_hold_count_next = hold_count;
        if (hold_count >= stop_hold_ticks) finish = 1'b1;
      end
      default: begin
        state_next       = ST_IDLE;
        phase_timer_next = 16'd0;
      end
    endcase

    if (finish) begin
      state_next       = ST_IDLE;
      phase_timer_next = 16'd0;
    end
  end

  // Bus levels and status from the state after this tick
  always_comb begin
    res_next            = '0;
    res_next.scl_out    = 1'b1;
    res_next.sda_out    = 1'b1;
    res_next.sda_drive  = 1'b0;
    res_next.busy_res   = state_next != ST_IDLE;
    res_next.done_res   = finish;
    if (finish) begin
      res_next.status = pending_status;
      if (pending_status == STATUS_OK && request_kind == REQ_READ) begin
        res_next.read_value = read_accum;
      end
    end

    unique case (state_next)
      ST_START_A: begin
        res_next.sda_drive = 1'b1;
      end
      ST_START_B: begin
        res_next.sda_out   = 1'b0;
        res_next.sda_drive = 1'b1;
      end
      ST_TX_LO: begin
        res_next.scl_out   = 1'b0;
        res_next.sda_out   = shift_reg_next[7];
        res_next.sda_drive = 1'b1;
      end
      ST_TX_HI: begin
        res_next.sda_out   = shift_reg_next[7];
        res_next.sda_drive = 1'b1;
      end
      ST_ACK_LO, ST_RX_LO: begin
        res_next.scl_out = 1'b0;
      end
      ST_MACK_LO: begin
        res_next.scl_out   = 1'b0;
        res_next.sda_out   = bit_count_next != 4'd8;
        res_next.sda_drive = 1'b1;
      end
      ST_MACK_HI: begin
        res_next.sda_out   = bit_count_next != 4'd8;
        res_next.sda_drive = 1'b1;
      end
      ST_STOP_A: begin
        res_next.scl_out   = 1'b0;
        res_next.sda_out   = 1'b0;
        res_next.sda_drive = 1'b1;
      end
      ST_STOP_B: begin
        res_next.sda_out   = 1'b0;
        res_next.sda_drive = 1'b1;
      end
      ST_STOP_C: begin
        res_next.sda_drive = 1'b1;
      end
      default: begin
        res_next.scl_out = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte    <= ADDRESS_BYTE_RESET;
      phase_ticks     <= PHASE_TICKS_RESET;
      ack_timeout     <= ACK_TIMEOUT_RESET;
      stop_hold_ticks <= STOP_HOLD_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADDRESS_BYTE:    address_byte    <= cfg_data[7:0];
        REG_PHASE_TICKS:     phase_ticks     <= cfg_data[15:0];
        REG_ACK_TIMEOUT:     ack_timeout     <= cfg_data[15:0];
        REG_STOP_HOLD_TICKS: stop_hold_ticks <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase_timer     <= 16'd0;
      bit_count       <= 4'd0;
      shift_reg       <= 8'd0;
      ack_poll_count  <= 16'd0;
      stop_hold_count <= 24'd0;
      read_accum      <= 16'd0;
      request_kind    <= 1'b0;
      pending_status  <= STATUS_OK;
      res_valid       <= 1'b0;
    end else begin
      if (tick_fire) begin
        state           <= state_next;
        phase_timer     <= phase_timer_next;
        bit_count       <= bit_count_next;
        shift_reg       <= shift_reg_next;
        ack_poll_count  <= ack_poll_count_next;
        stop_hold_count <= stop_hold_count_next;
        read_accum      <= read_accum_next;
        request_kind    <= request_kind_next;
        pending_status  <= pending_status_next;
        res_valid       <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload holds until replaced by the next tick
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      res_data <= res_next;
    end
  end

  // A request seen while idle starts a transaction; none seen keeps idle
  assert property (@(posedge clk) disable iff (rst)
    tick_fire && state == ST_IDLE && !in.req_valid |=> state == ST_IDLE)
    else $error("sequencer left idle without a request");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.done_res |->
      res_data.status == STATUS_OK && res_data.read_value == 16'd0)
    else $error("status or read value outside a done tick");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> !res_data.busy_res && state == ST_IDLE)
    else $error("done reported while transaction still running");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.sda_drive |-> res_data.sda_out)
    else $error("released SDA reported low");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int     TOTAL_TICKS    = 1050;
  localparam longint CYCLE_LIMIT    = 500_000;
  localparam int     NO_ACK         = 32'h7FFF_FFFF;
  localparam int     MAX_REPORTS    = 10;
  localparam int     ROW_COUNT      = 13;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_TX_LO, PH_TX_HI, PH_ACK_LO, PH_ACK_POLL,
    PH_RX_LO, PH_RX_HI, PH_MACK_LO, PH_MACK_HI, PH_STOP_A, PH_STOP_B, PH_STOP_C,
    PH_HOLD
  } bus_phase_e;

  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] phase;
    logic [15:0] timeout;
    logic [23:0] hold;
  } bus_setting_t;

  typedef struct packed {
    int          setting;
    logic        kind;
    logic [7:0]  cmd;
    int          addr_wait;
    int          data_wait;
    logic [15:0] word;
    logic        chaos;
    logic        typed;
    logic [1:0]  want_status;
    logic [15:0] want_value;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     sink_ready = 1'b0;

  i2cm_tick_if   tick_ch ();
  i2cm_result_if result_ch ();

  assign result_ch.ready = sink_ready;

  i2c_sensor_command_and_read_master u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Sequencer copy
  bus_phase_e  seq_phase;
  logic [15:0] seq_timer;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [15:0] seq_polls;
  logic [23:0] seq_hold;
  logic [15:0] seq_accum;
  logic        seq_kind;
  logic [1:0]  seq_status;

  logic [7:0]  reg_addr;
  logic [15:0] reg_phase;
  logic [15:0] reg_timeout;
  logic [23:0] reg_hold;

  // Device behavior for the running transfer
  int          dev_addr_wait;
  int          dev_data_wait;
  logic [15:0] dev_word;
  logic        dev_chaos;

  logic        fixed_active;
  logic [1:0]  fixed_status;
  logic [15:0] fixed_value;

  result_t       bus_view_q[$];
  int            mismatches   = 0;
  int            results_seen = 0;
  int            ticks_sent   = 0;
  int            stall_left   = 0;
  int            src_gap_pct  = 0;
  int            sink_stall_pct = 0;
  longint        cycles       = 0;
  bus_setting_t  settings [4];
  directed_row_t directed_rows [ROW_COUNT];

  function automatic void reset_sequencer();
    reg_addr    = ADDRESS_BYTE_RESET;
    reg_phase   = PHASE_TICKS_RESET;
    reg_timeout = ACK_TIMEOUT_RESET;
    reg_hold    = STOP_HOLD_TICKS_RESET;
    seq_phase   = PH_IDLE;
    seq_timer   = '0;
    seq_bits    = '0;
    seq_shift   = '0;
    seq_polls   = '0;
    seq_hold    = '0;
    seq_accum   = '0;
    seq_kind    = REQ_WRITE;
    seq_status  = STATUS_OK;
  endfunction

  function automatic void enter(input bus_phase_e ph);
    seq_phase = ph;
    seq_timer = '0;
  endfunction

  function automatic logic phase_done();
    logic [15:0] lim;
    lim = (reg_phase == 16'd0) ? 16'd1 : reg_phase;
    seq_timer = seq_timer + 16'd1;
    if (seq_timer >= lim) begin
      seq_timer = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_sequencer(input tick_t t);
    result_t r;
    logic    finish;
    finish = 1'b0;
    r = '0;
    case (seq_phase)
      PH_IDLE: if (t.req_valid) begin
        seq_kind   = t.req_type;
        seq_shift  = reg_addr | {7'd0, t.req_type};
        seq_accum  = (t.req_type == REQ_READ) ? 16'd0 : {8'd0, t.cmd_byte};
        seq_bits   = '0;
        seq_polls  = '0;
        seq_hold   = '0;
        seq_status = STATUS_OK;
        enter(PH_START_A);
      end
      PH_START_A: if (phase_done()) enter(PH_START_B);
      PH_START_B: if (phase_done()) enter(PH_TX_LO);
      PH_TX_LO:   if (phase_done()) enter(PH_TX_HI);
      PH_TX_HI: if (phase_done()) begin
        seq_shift = seq_shift << 1;
        seq_bits  = seq_bits + 4'd1;
        if (seq_bits[2:0] == 3'd0) enter(PH_ACK_LO);
        else enter(PH_TX_LO);
      end
      PH_ACK_LO: if (phase_done()) begin
        seq_polls = '0;
        enter(PH_ACK_POLL);
      end
      PH_ACK_POLL: begin
        if (!t.sda_in) begin
          if (seq_bits == 4'd8 && seq_kind == REQ_READ) begin
            seq_bits  = '0;
            seq_accum = '0;
            enter(PH_RX_LO);
          end else if (seq_bits == 4'd8) begin
            seq_shift = seq_accum[7:0];
            enter(PH_TX_LO);
          end else begin
            enter(PH_STOP_A);
          end
        end else if (seq_polls >= reg_timeout) begin
          seq_status = (seq_bits == 4'd8) ? STATUS_NO_ADDR_ACK : STATUS_NO_DATA_ACK;
          enter(PH_STOP_A);
        end else begin
          seq_polls = seq_polls + 16'd1;
        end
      end
      PH_RX_LO: if (phase_done()) enter(PH_RX_HI);
      PH_RX_HI: if (phase_done()) begin
        seq_accum = {seq_accum[14:0], t.sda_in};
        seq_bits  = seq_bits + 4'd1;
        if (seq_bits[2:0] == 3'd0) enter(PH_MACK_LO);
        else enter(PH_RX_LO);
      end
      PH_MACK_LO: if (phase_done()) enter(PH_MACK_HI);
      PH_MACK_HI: if (phase_done()) begin
        if (seq_bits == 4'd8) enter(PH_RX_LO);
        else enter(PH_STOP_A);
      end
      PH_STOP_A: if (phase_done()) enter(PH_STOP_B);
      PH_STOP_B: if (phase_done()) enter(PH_STOP_C);
      PH_STOP_C: if (phase_done()) begin
        seq_hold = '0;
        if (reg_hold == 24'd0) finish = 1'b1;
        else enter(PH_HOLD);
      end
      PH_HOLD: begin
        seq_hold = seq_hold + 24'd1;
        if (seq_hold >= reg_hold) finish = 1'b1;
      end
      default: enter(PH_IDLE);
    endcase

    if (finish) begin
      enter(PH_IDLE);
      r.done_res   = 1'b1;
      r.status     = seq_status;
      r.read_value = (seq_status == STATUS_OK && seq_kind == REQ_READ) ? seq_accum : 16'd0;
    end

    r.scl_out   = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b0;
    case (seq_phase)
      PH_START_A: r.sda_drive = 1'b1;
      PH_START_B: begin
        r.sda_out   = 1'b0;
        r.sda_drive = 1'b1;
      end
      PH_TX_LO: begin
        r.scl_out   = 1'b0;
        r.sda_out   = seq_shift[7];
        r.sda_drive = 1'b1;
      end
      PH_TX_HI: begin
        r.sda_out   = seq_shift[7];
        r.sda_drive = 1'b1;
      end
      PH_ACK_LO, PH_RX_LO: r.scl_out = 1'b0;
      PH_MACK_LO: begin
        r.scl_out   = 1'b0;
        r.sda_out   = (seq_bits != 4'd8);
        r.sda_drive = 1'b1;
      end
      PH_MACK_HI: begin
        r.sda_out   = (seq_bits != 4'd8);
        r.sda_drive = 1'b1;
      end
      PH_STOP_A: begin
        r.scl_out   = 1'b0;
        r.sda_out   = 1'b0;
        r.sda_drive = 1'b1;
      end
      PH_STOP_B: begin
        r.sda_out   = 1'b0;
        r.sda_drive = 1'b1;
      end
      PH_STOP_C: r.sda_drive = 1'b1;
      default: ;
    endcase
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // Level the device puts on SDA for the next tick, given where the master is
  function automatic logic device_sda();
    int wait_len;
    if (dev_chaos) return $urandom_range(0, 1) != 0;
    case (seq_phase)
      PH_ACK_POLL: begin
        wait_len = (seq_bits == 4'd8) ? dev_addr_wait : dev_data_wait;
        return (seq_polls >= wait_len) ? 1'b0 : 1'b1;
      end
      PH_RX_LO, PH_RX_HI: return dev_word[4'd15 - seq_bits];
      default: return $urandom_range(0, 1) != 0;
    endcase
  endfunction

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_wait(input int limit);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(0, limit);
    if (roll < 93) return limit + 1;
    return NO_ACK;
  endfunction

  task automatic send_tick(input logic want_req, input logic kind, input logic [7:0] cmd);
    tick_t   t;
    result_t r;
    int      gap;
    gap = idle_len(src_gap_pct);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t.req_valid = want_req;
    t.req_type  = kind;
    t.cmd_byte  = cmd;
    t.sda_in    = device_sda();
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    ticks_sent++;
    r = advance_sequencer(t);
    if (r.done_res && fixed_active) begin
      r.status     = fixed_status;
      r.read_value = fixed_value;
    end
    bus_view_q.push_back(r);
  endtask

  // Offer one request, then clock the bus until the transfer is over
  task automatic run_request(input logic kind, input logic [7:0] cmd);
    send_tick(1'b1, kind, cmd);
    while (seq_phase != PH_IDLE)
      send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1) != 0,
                8'($urandom_range(0, 255)));
    fixed_active = 1'b0;
  endtask

  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    while (bus_view_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setting(input bus_setting_t s);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_ADDRESS_BYTE;
    cfg_data  <= {16'd0, s.addr};
    @(posedge clk);
    cfg_index <= REG_PHASE_TICKS;
    cfg_data  <= {8'd0, s.phase};
    @(posedge clk);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= {8'd0, s.timeout};
    @(posedge clk);
    cfg_index <= REG_STOP_HOLD_TICKS;
    cfg_data  <= s.hold;
    @(posedge clk);
    cfg_write   <= 1'b0;
    reg_addr    = s.addr;
    reg_phase   = s.phase;
    reg_timeout = s.timeout;
    reg_hold    = s.hold;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result %0d %s: expected %h got %h",
                 $time, results_seen, name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (bus_view_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] result %0d with no request pending: %h", $time, results_seen, got);
    end else begin
      want = bus_view_q.pop_front();
      check_field("scl_out", want.scl_out, got.scl_out);
      check_field("sda_out", want.sda_out, got.sda_out);
      check_field("sda_drive", want.sda_drive, got.sda_drive);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("done_res", want.done_res, got.done_res);
      check_field("status", want.status, got.status);
      check_field("read_value", want.read_value, got.read_value);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && sink_ready) check_result(result_ch.data);
    if (stall_left == 0) stall_left = idle_len(sink_stall_pct);
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_sensor_command_and_read_master verification failed");
      $finish;
    end
  end

  initial begin
    bus_setting_t  s;
    directed_row_t row;
    int            cur_setting;
    int            batch;
    logic          kind;

    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    reset_sequencer();
    fixed_active  = 1'b0;
    dev_chaos     = 1'b0;
    cur_setting   = -1;

    settings = '{
      '{8'd0,   16'd0,     16'd3,     24'd0},
      '{8'd254, 16'd2,     16'd1,     24'd3},
      '{8'd71,  16'd1,     16'd2,     24'd1},
      '{8'd254, 16'd65535, 16'd65535, 24'd16777215}
    };

    // setting, kind, cmd, addr wait, data wait, word, chaos, typed, status, value
    directed_rows = '{
      '{0,  REQ_WRITE, 8'h00, 0,      0,      16'h0000, 1'b0, 1'b1, STATUS_OK,          16'h0000},
      '{0,  REQ_WRITE, 8'hFF, 3,      3,      16'h0000, 1'b0, 1'b1, STATUS_OK,          16'h0000},
      '{0,  REQ_READ,  8'h00, 0,      0,      16'hFFFF, 1'b0, 1'b1, STATUS_OK,          16'hFFFF},
      '{0,  REQ_WRITE, 8'h81, NO_ACK, 0,      16'h0000, 1'b0, 1'b1, STATUS_NO_ADDR_ACK, 16'h0000},
      '{0,  REQ_WRITE, 8'h7E, 0,      4,      16'h0000, 1'b0, 1'b1, STATUS_NO_DATA_ACK, 16'h0000},
      '{0,  REQ_READ,  8'h00, 4,      0,      16'hBEEF, 1'b0, 1'b1, STATUS_NO_ADDR_ACK, 16'h0000},
      '{0,  REQ_READ,  8'h00, 3,      0,      16'hA55A, 1'b0, 1'b1, STATUS_OK,          16'hA55A},
      '{1,  REQ_READ,  8'h00, 1,      0,      16'h8001, 1'b0, 1'b1, STATUS_OK,          16'h8001},
      '{1,  REQ_WRITE, 8'h01, 0,      NO_ACK, 16'h0000, 1'b0, 1'b1, STATUS_NO_DATA_ACK, 16'h0000},
      '{1,  REQ_READ,  8'h00, 0,      0,      16'h0000, 1'b1, 1'b0, STATUS_OK,          16'h0000},
      '{2,  REQ_WRITE, 8'h3C, 2,      1,      16'h0000, 1'b0, 1'b1, STATUS_OK,          16'h0000},
      '{2,  REQ_READ,  8'h00, 2,      0,      16'h1234, 1'b0, 1'b1, STATUS_OK,          16'h1234},
      '{2,  REQ_WRITE, 8'hC3, 0,      3,      16'h0000, 1'b0, 1'b1, STATUS_NO_DATA_ACK, 16'h0000}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle bus straight out of reset
    repeat (4) send_tick(1'b0, $urandom_range(0, 1) != 0, 8'($urandom_range(0, 255)));

    for (int i = 0; i < ROW_COUNT; i++) begin
      row = directed_rows[i];
      if (row.setting != cur_setting) begin
        apply_setting(settings[row.setting]);
        cur_setting = row.setting;
      end
      src_gap_pct    = 25;
      sink_stall_pct = 25;
      dev_addr_wait  = row.addr_wait;
      dev_data_wait  = row.data_wait;
      dev_word       = row.word;
      dev_chaos      = row.chaos;
      fixed_active   = row.typed;
      fixed_status   = row.want_status;
      fixed_value    = row.want_value;
      run_request(row.kind, row.cmd);
    end

    // widest register values: clock an idle bus only
    apply_setting(settings[3]);
    dev_chaos = 1'b0;
    repeat (4) send_tick(1'b0, $urandom_range(0, 1) != 0, 8'($urandom_range(0, 255)));

    while (ticks_sent < TOTAL_TICKS) begin
      s.addr    = 8'($urandom_range(0, 254));
      s.phase   = ($urandom_range(0, 9) == 0) ? 16'd2 : 16'($urandom_range(0, 1));
      s.timeout = 16'($urandom_range(1, 6));
      s.hold    = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom_range(1, 4));
      apply_setting(s);
      case ($urandom_range(0, 3))
        0: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct    = $urandom_range(10, 40);
          sink_stall_pct = 0;
        end
        2: begin
          src_gap_pct    = 0;
          sink_stall_pct = $urandom_range(10, 40);
        end
        default: begin
          src_gap_pct    = $urandom_range(10, 30);
          sink_stall_pct = $urandom_range(10, 30);
        end
      endcase
      batch = $urandom_range(1, 3);
      for (int b = 0; b < batch && ticks_sent < TOTAL_TICKS; b++) begin
        kind          = $urandom_range(0, 1) != 0;
        dev_addr_wait = pick_wait(s.timeout);
        dev_data_wait = pick_wait(s.timeout);
        case ($urandom_range(0, 9))
          0:       dev_word = 16'h0000;
          1:       dev_word = 16'hFFFF;
          default: dev_word = 16'($urandom);
        endcase
        dev_chaos = ($urandom_range(0, 24) == 0);
        repeat ($urandom_range(0, 2))
          send_tick(1'b0, $urandom_range(0, 1) != 0, 8'($urandom_range(0, 255)));
        run_request(kind, 8'($urandom_range(0, 255)));
        // now and then, hold the bus until every result is back
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && bus_view_q.size() == 0) begin
      $display("i2c_sensor_command_and_read_master verification clean");
    end else begin
      $display("i2c_sensor_command_and_read_master verification failed");
    end
    $finish;
  end

endmodule
